// ===== rtl/lc3bmc_pkg.sv =====
// Shared types, constants and helpers for the LC-3b microcoded core.
package lc3bmc_pkg;

    localparam int MEM_WORDS_DEF   = 32768;
    localparam int CS_ROWS_DEF     = 64;
    localparam int REG_COUNT_DEF   = 8;
    localparam int MEM_LATENCY_DEF = 5;

    localparam int MW_W        = 35;
    localparam int WORD_W      = 16;
    localparam int MADDR_W     = 15;
    localparam int STATE_W     = 6;
    localparam logic [STATE_W-1:0] START_STATE = 6'd18;
    localparam logic [2:0]  NZP_Z   = 3'b010;
    localparam logic [2:0]  NZP_N   = 3'b100;
    localparam logic [2:0]  NZP_P   = 3'b001;

    // Item commands
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_LOAD_CS = 2'd1,
        CMD_LOAD_MEM = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // Microword bit positions (control bit j sits at bit 34-j)
    localparam int B_IRD = 34, B_COND1 = 33, B_COND0 = 32, B_J_HI = 31, B_J_LO = 26;
    localparam int B_LDMAR = 25, B_LDMDR = 24, B_LDIR = 23, B_LDBEN = 22;
    localparam int B_LDREG = 21, B_LDCC = 20, B_LDPC = 19;
    localparam int B_GPC = 18, B_GMDR = 17, B_GALU = 16, B_GMARMUX = 15, B_GSHF = 14;
    localparam int B_PCMUX1 = 13, B_PCMUX0 = 12, B_DRMUX = 11, B_SR1MUX = 10;
    localparam int B_ADDR1MUX = 9, B_ADDR2MUX1 = 8, B_ADDR2MUX0 = 7, B_MARMUX = 6;
    localparam int B_ALUK1 = 5, B_ALUK0 = 4, B_MIOEN = 3, B_RW = 2, B_DSIZE = 1;
    localparam int B_LSHF1 = 0;

    // Microsequencer conditions
    localparam logic [1:0] COND_READY = 2'd1;
    localparam logic [1:0] COND_BEN   = 2'd2;
    localparam logic [1:0] COND_IR11  = 2'd3;

    // ALU operations
    localparam logic [1:0] ALU_ADD = 2'd0, ALU_AND = 2'd1, ALU_XOR = 2'd2;

    // PC sources
    localparam logic [1:0] PC_INC = 2'd0, PC_BUS = 2'd1, PC_ADDER = 2'd2;

    // Address-2 sources
    localparam logic [1:0] A2_OFF6 = 2'd1, A2_OFF9 = 2'd2, A2_OFF11 = 2'd3;

    // Shift types
    localparam logic [1:0] SHF_LSL = 2'd0, SHF_LSR = 2'd1, SHF_ASR = 2'd3;

    // Memory port request from the core to the main memory
    typedef struct packed {
        logic               we;
        logic [MADDR_W-1:0] waddr;
        logic [WORD_W-1:0]  wdata;
        logic [MADDR_W-1:0] raddr;
    } mem_req_t;

    // Sign-extend the low bits of a word to 16 bits
    function automatic logic [WORD_W-1:0] sext(input logic [WORD_W-1:0] v, input int bits);
        logic [WORD_W-1:0] r;
        r = v;
        for (int i = 0; i < WORD_W; i++) begin
            if (i >= bits) begin
                r[i] = v[bits-1];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/lc3b_microcoded_core_unit.sv =====
// LC-3b microcoded core: one item per cycle while s_tready is high (the memory clear
// and output back-pressure hold it low); the result is loaded into the output register
// in the cycle after the transfer. Control store and memory read ports are prefetched
// at the next microstate and next MAR, so a tick never waits on a read.
// Reset: synchronous, active low; then a sweep zeroes the main memory, during which
// s_tready stays low (configuration writes are still taken).
module lc3b_microcoded_core_unit
    import lc3bmc_pkg::*;
#(
    parameter int MEM_WORDS   = MEM_WORDS_DEF,
    parameter int CS_ROWS     = CS_ROWS_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF,
    parameter int MEM_LATENCY = MEM_LATENCY_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,     // start_pc
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,         // cmd[1:0], index[16:2], value[51:17], zeros
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata          // pc[15:0], ir[31:16], state[37:32],
                                           // bus[53:38], mar[69:54], mdr[85:70],
                                           // nzp[88:86], halted[89], zeros
);
    localparam int CSA_W = $clog2(CS_ROWS);
    localparam int RA_W  = $clog2(REG_COUNT);

    // Input fields
    logic [1:0]        in_cmd;
    logic [14:0]       in_index;
    logic [MW_W-1:0]   in_value;
    assign in_cmd   = s_tdata[1:0];
    assign in_index = s_tdata[16:2];
    assign in_value = s_tdata[51:17];

    // Architectural state
    logic [WORD_W-1:0] pc_reg, pc_next, ir_reg, ir_next, mar_reg, mar_next;
    logic [WORD_W-1:0] mdr_reg, mdr_next, mrd_reg, mrd_next;
    logic [STATE_W-1:0] ms_reg, ms_next;
    logic [2:0]        nzp_reg, nzp_next, mcyc_reg, mcyc_next;
    logic              ben_reg, ben_next, rdy_reg, rdy_next;
    logic [WORD_W-1:0] rf_reg [REG_COUNT];

    logic [MW_W-1:0]   cs_mem [CS_ROWS];
    logic [MW_W-1:0]   mw;           // prefetched microword of ms_reg

    logic              out_valid_reg;
    logic [103:0]      out_data_reg;

    mem_req_t          mreq;
    logic [WORD_W-1:0] mem_rdata;
    logic              mem_busy;

    logic accept, tick_en, cs_we, mem_done;
    logic [WORD_W-1:0] bus, a1, a2, addr_sum, marmux, sr1, sr2, alu, shf, sv, mdr_gate;
    logic [WORD_W-1:0] mem_wword;
    logic [RA_W-1:0]   dr;
    logic [STATE_W-1:0] nxt;
    logic [2:0]        mcyc_inc;

    assign s_tready = !mem_busy && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign tick_en  = accept && in_cmd == CMD_TICK && pc_reg != '0;
    assign cs_we    = accept && in_cmd == CMD_LOAD_CS && in_index < 15'(CS_ROWS);

    // Microsequencer
    always_comb begin
        if (mw[B_IRD]) begin
            nxt = {2'b00, ir_reg[15:12]};
        end else begin
            nxt = mw[B_J_HI:B_J_LO];
            case ({mw[B_COND1], mw[B_COND0]})
                COND_READY: nxt[1] = nxt[1] | rdy_reg;
                COND_BEN:   nxt[2] = nxt[2] | ben_reg;
                COND_IR11:  nxt[0] = nxt[0] | ir_reg[11];
                default:    ;
            endcase
        end
    end

    // Address adders and MARMUX
    always_comb begin
        case ({mw[B_ADDR2MUX1], mw[B_ADDR2MUX0]})
            A2_OFF6:  a2 = sext(ir_reg, 6);
            A2_OFF9:  a2 = sext(ir_reg, 9);
            A2_OFF11: a2 = sext(ir_reg, 11);
            default:  a2 = '0;
        endcase
        if (mw[B_LSHF1]) begin
            a2 = {a2[WORD_W-2:0], 1'b0};
        end
        a1       = mw[B_ADDR1MUX] ? rf_reg[ir_reg[8:6]] : pc_reg;
        addr_sum = a1 + a2;
        marmux   = mw[B_MARMUX] ? addr_sum : {7'd0, ir_reg[7:0], 1'b0};
    end

    // ALU and shifter
    always_comb begin
        sr2 = ir_reg[5] ? sext(ir_reg, 5) : rf_reg[ir_reg[2:0]];
        sr1 = mw[B_SR1MUX] ? rf_reg[ir_reg[8:6]] : rf_reg[ir_reg[11:9]];
        case ({mw[B_ALUK1], mw[B_ALUK0]})
            ALU_ADD: alu = sr1 + sr2;
            ALU_AND: alu = sr1 & sr2;
            ALU_XOR: alu = sr1 ^ sr2;
            default: alu = sr1;
        endcase
        sv = rf_reg[ir_reg[8:6]];
        case (ir_reg[5:4])
            SHF_LSL: shf = sv << ir_reg[3:0];
            SHF_LSR: shf = sv >> ir_reg[3:0];
            SHF_ASR: shf = WORD_W'($signed(sv) >>> ir_reg[3:0]);
            default: shf = '0;
        endcase
        mdr_gate = mw[B_DSIZE] ? mdr_reg : sext(mdr_reg, 8);
    end

    // Gated bus, fixed priority
    always_comb begin
        bus = '0;
        if (tick_en) begin
            if (mw[B_GPC])          bus = pc_reg;
            else if (mw[B_GMARMUX]) bus = marmux;
            else if (mw[B_GMDR])    bus = mdr_gate;
            else if (mw[B_GALU])    bus = alu;
            else if (mw[B_GSHF])    bus = shf;
        end
    end

    // Memory handshake and register next values
    always_comb begin
        mcyc_inc  = mcyc_reg + 3'd1;
        mem_done  = tick_en && mw[B_MIOEN] && mcyc_inc == 3'(MEM_LATENCY);
        mem_wword = mem_rdata;
        if (mw[B_DSIZE])       mem_wword = mdr_reg;
        else if (mar_reg[0])   mem_wword[15:8] = mdr_reg[7:0];
        else                   mem_wword[7:0]  = mdr_reg[7:0];

        pc_next = pc_reg;   ir_next = ir_reg;   mar_next = mar_reg;  mdr_next = mdr_reg;
        mrd_next = mrd_reg; ms_next = ms_reg;   nzp_next = nzp_reg;  ben_next = ben_reg;
        rdy_next = rdy_reg; mcyc_next = mcyc_reg;
        dr = mw[B_DRMUX] ? RA_W'(REG_COUNT - 1) : ir_reg[11:9];

        if (cfg_wr_en) begin
            pc_next = cfg_wr_data;
        end
        if (tick_en) begin
            ms_next = nxt;
            if (mw[B_MIOEN]) begin
                mcyc_next = mcyc_inc;
                if (mcyc_inc == 3'(MEM_LATENCY - 1)) rdy_next = 1'b1;
                if (mem_done) begin
                    rdy_next  = 1'b0;
                    mcyc_next = '0;
                    if (!mw[B_RW]) begin
                        if (mw[B_DSIZE])     mrd_next = mem_rdata;
                        else if (mar_reg[0]) mrd_next = sext({8'd0, mem_rdata[15:8]}, 8);
                        else                 mrd_next = sext(mem_rdata, 8);
                    end
                end
            end
            if (mw[B_LDBEN]) begin
                ben_next = (ir_reg[11] && nzp_reg[2]) || (ir_reg[10] && nzp_reg[1]) ||
                           (ir_reg[9] && nzp_reg[0]);
            end
            if (mw[B_LDMAR]) mar_next = bus;
            if (mw[B_LDIR])  ir_next  = bus;
            if (mw[B_LDCC]) begin
                nzp_next = (bus == '0) ? NZP_Z : (bus[15] ? NZP_N : NZP_P);
            end
            if (mw[B_LDPC]) begin
                case ({mw[B_PCMUX1], mw[B_PCMUX0]})
                    PC_INC:   pc_next = pc_reg + 16'd2;
                    PC_BUS:   pc_next = bus;
                    PC_ADDER: pc_next = addr_sum;
                    default:  ;
                endcase
            end
            // MDR takes the read data of an access that completes on this tick
            if (mw[B_LDMDR]) mdr_next = mw[B_MIOEN] ? mrd_next : bus;
        end
    end

    // Main memory request: loads or the write at the end of an access
    always_comb begin
        mreq.raddr = mar_next[15:1];
        mreq.we    = 1'b0;
        mreq.waddr = mar_reg[15:1];
        mreq.wdata = mem_wword;
        if (accept && in_cmd == CMD_LOAD_MEM && {1'b0, in_index} < 16'(MEM_WORDS)) begin
            mreq.we    = 1'b1;
            mreq.waddr = in_index;
            mreq.wdata = in_value[WORD_W-1:0];
        end else if (mem_done && mw[B_RW]) begin
            mreq.we = 1'b1;
        end
    end

    lc3bmc_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rdata   (mem_rdata),
        .busy    (mem_busy)
    );

    // Control store: write on load, prefetch the row of the next state
    always_ff @(posedge aclk) begin
        if (cs_we) begin
            cs_mem[in_index[CSA_W-1:0]] <= in_value;
        end
        if (cs_we && in_index[CSA_W-1:0] == ms_next[CSA_W-1:0]) begin
            mw <= in_value;
        end else begin
            mw <= cs_mem[ms_next[CSA_W-1:0]];
        end
    end

    // Core registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0; ir_reg <= '0; mar_reg <= '0; mdr_reg <= '0; mrd_reg <= '0;
            ms_reg <= START_STATE; nzp_reg <= NZP_Z; ben_reg <= 1'b0;
            rdy_reg <= 1'b0; mcyc_reg <= '0;
            for (int i = 0; i < REG_COUNT; i++) begin
                rf_reg[i] <= '0;
            end
        end else begin
            pc_reg <= pc_next; ir_reg <= ir_next; mar_reg <= mar_next; mdr_reg <= mdr_next;
            mrd_reg <= mrd_next; ms_reg <= ms_next; nzp_reg <= nzp_next;
            ben_reg <= ben_next; rdy_reg <= rdy_next; mcyc_reg <= mcyc_next;
            if (tick_en && mw[B_LDREG]) begin
                rf_reg[dr] <= bus;
            end
        end
    end

    // Output register: load on transfer in, drop on transfer out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {14'd0, pc_next == '0, nzp_next, mdr_next, mar_next, bus,
                             ms_next, ir_next, pc_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_busy |-> !s_tready) else $error("item taken during memory clear");
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid) else $error("accepted item gave no result");
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_cmd == CMD_TICK && pc_reg == '0) |=> m_tdata[53:38] == '0)
        else $error("refused tick drove the bus");
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !tick_en |=> $stable(ms_reg)) else $error("microstate moved without a tick");

endmodule

// ===== rtl/lc3bmc_mem.sv =====
// Main memory: one write port, one registered read port, clearing sweep after reset.
module lc3bmc_mem
    import lc3bmc_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF   // power of two
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rdata,
    output logic              busy
);
    localparam int AW = $clog2(MEM_WORDS);

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [AW:0]       clr_cnt_reg;
    logic [WORD_W-1:0] rdata_reg;

    assign busy  = !clr_cnt_reg[AW];
    assign rdata = rdata_reg;

    // Advance the clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (busy) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Write port: zeros during the sweep, else the core's request
    always_ff @(posedge aclk) begin
        if (busy) begin
            mem[clr_cnt_reg[AW-1:0]] <= '0;
        end else if (req.we) begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    // Read port, forwarding a same-cycle write to the read address
    always_ff @(posedge aclk) begin
        if (!aresetn || busy) begin
            rdata_reg <= '0;
        end else if (req.we && req.waddr[AW-1:0] == req.raddr[AW-1:0]) begin
            rdata_reg <= req.wdata;
        end else begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

endmodule
